// ===== rtl/core/ibm1em_pkg.sv =====
package ibm1em_pkg;

    // Fixed field and table widths.
    localparam int WORD_W      = 3;
    localparam int VOC_W       = 4;
    localparam int ITER_W      = 8;
    localparam int OP_W        = 2;
    localparam int VOCAB_LIM   = 8;
    localparam int PROB_W      = 16;
    localparam int CNT_W       = 24;
    localparam int TAB_AW      = 2 * WORD_W;
    localparam int TAB_DEPTH   = 1 << TAB_AW;
    localparam int NUM_W       = 40;
    localparam int DEN_W       = 27;
    localparam int QUO_W       = 17;
    localparam int SHARE_SHIFT = 16;
    localparam int NORM_SHIFT  = 15;
    localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};
    localparam logic [PROB_W-1:0] PROB_ONE = 16'h8000;

    // Configuration port.
    localparam int CFG_AW = 4;
    localparam int CFG_DW = 32;
    localparam logic [1:0] REG_SRC_VOCAB  = 2'd0;
    localparam logic [1:0] REG_OBS_VOCAB  = 2'd1;
    localparam logic [1:0] REG_ITERATIONS = 2'd2;
    localparam logic [VOC_W-1:0]  RST_SRC_VOCAB  = 4'd3;
    localparam logic [VOC_W-1:0]  RST_OBS_VOCAB  = 4'd3;
    localparam logic [ITER_W-1:0] RST_ITERATIONS = 8'd50;

    // Input operation codes. The last one is accepted and ignored.
    localparam logic [OP_W-1:0] OP_SRC   = 2'd0;
    localparam logic [OP_W-1:0] OP_OBS   = 2'd1;
    localparam logic [OP_W-1:0] OP_TRAIN = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_INIT,
        ST_ITER_END,
        ST_CLEAR,
        ST_PAIR_CHK,
        ST_PAIR_LD,
        ST_OBS_CHK,
        ST_OBS_LD,
        ST_SUM_CHK,
        ST_SUM_SRC,
        ST_SUM_ADD,
        ST_SH_CHK,
        ST_SH_SRC,
        ST_SH_PROB,
        ST_SH_DIV,
        ST_NS_CHK,
        ST_NT_CHK,
        ST_NT_ACC,
        ST_NQ_CHK,
        ST_NQ_RD,
        ST_NQ_DIV,
        ST_EM_START,
        ST_EM_RD,
        ST_EM_LD,
        ST_EM_WAIT
    } state_t;

    typedef struct packed {
        logic in_ready;
        logic idx_clr;
        logic idx_inc;
        logic prob_wr_uni;
        logic prob_wr_norm;
        logic cnt_wr_zero;
        logic cnt_wr_acc;
        logic iter_clr;
        logic iter_inc;
        logic pair_clr;
        logic pair_next;
        logic plen_latch;
        logic j_clr;
        logic j_inc;
        logic o_latch;
        logic i_clr;
        logic i_inc;
        logic sum_clr;
        logic sum_acc;
        logic s_latch;
        logic prob_addr_word;
        logic div_start_share;
        logic div_start_norm;
        logic o_clr;
        logic o_inc;
        logic s_clr;
        logic s_inc;
        logic total_clr;
        logic total_acc;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic train_req;
        logic idx_last;
        logic iter_hit;
        logic p_end;
        logic j_end;
        logic obs_ok;
        logic i_end;
        logic sum_zero;
        logic src_ok;
        logic s_end;
        logic o_end;
        logic o_last;
        logic total_zero;
        logic div_done;
        logic out_accept;
        logic out_last;
        logic emit_empty;
    } stat_t;

    // Uniform start value round(32768 / n) for the clamped vocabulary size.
    function automatic logic [PROB_W-1:0] uni_prob(input logic [VOC_W-1:0] n);
        logic [PROB_W-1:0] v;
        case (n)
            4'd1:    v = 16'd32768;
            4'd2:    v = 16'd16384;
            4'd3:    v = 16'd10923;
            4'd4:    v = 16'd8192;
            4'd5:    v = 16'd6554;
            4'd6:    v = 16'd5461;
            4'd7:    v = 16'd4681;
            4'd8:    v = 16'd4096;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/ibm1em_ram.sv =====
module ibm1em_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/ibm1em_div.sv =====
module ibm1em_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [ibm1em_pkg::NUM_W-1:0]  num,
    input  logic [ibm1em_pkg::DEN_W-1:0]  den,
    output logic                          done,
    output logic [ibm1em_pkg::QUO_W-1:0]  quo
);
    import ibm1em_pkg::*;

    localparam int CW = $clog2(NUM_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CW-1:0]     cnt_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              ge;
    logic [DEN_W-1:0]  rem_next;

    // One quotient bit per cycle, restoring form.
    assign trial    = {rem_reg, num_reg[NUM_W-1]};
    assign diff     = trial - {1'b0, den_reg};
    assign ge       = (trial >= {1'b0, den_reg});
    assign rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NUM_W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
            quo_reg <= '0;
        end else if (busy_reg) begin
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[QUO_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ===== rtl/core/ibm1em_dp.sv =====
module ibm1em_dp #(
    parameter int SRC_VOCAB = 8,
    parameter int OBS_VOCAB = 8,
    parameter int MAX_PAIRS = 16,
    parameter int MAX_LEN   = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  ibm1em_pkg::cmd_t               cmd,
    output ibm1em_pkg::stat_t              stat,
    input  logic [ibm1em_pkg::VOC_W-1:0]   cfg_src_vocab,
    input  logic [ibm1em_pkg::VOC_W-1:0]   cfg_obs_vocab,
    input  logic [ibm1em_pkg::ITER_W-1:0]  cfg_iterations,
    input  logic                           s_valid,
    input  logic [ibm1em_pkg::OP_W-1:0]    s_operation,
    input  logic [ibm1em_pkg::WORD_W-1:0]  s_word,
    input  logic                           s_end_of_pair,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [ibm1em_pkg::WORD_W-1:0]  m_observed_index,
    output logic [ibm1em_pkg::WORD_W-1:0]  m_source_index,
    output logic [ibm1em_pkg::PROB_W-1:0]  m_probability,
    output logic                           m_last
);
    import ibm1em_pkg::*;

    localparam int LEN_W  = $clog2(MAX_LEN + 1);
    localparam int PT_W   = $clog2(MAX_PAIRS + 1);
    localparam int PA_W   = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
    localparam int WDEPTH = MAX_PAIRS * MAX_LEN;
    localparam int WA_W   = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
    localparam int BASE_W = $clog2(WDEPTH + 1);
    localparam int SUM_W  = PROB_W + LEN_W;
    localparam logic [VOC_W-1:0] SRC_LIM =
        VOC_W'((SRC_VOCAB < VOCAB_LIM) ? SRC_VOCAB : VOCAB_LIM);
    localparam logic [VOC_W-1:0] OBS_LIM =
        VOC_W'((OBS_VOCAB < VOCAB_LIM) ? OBS_VOCAB : VOCAB_LIM);

    logic [VOC_W-1:0]   ns;
    logic [VOC_W-1:0]   no;

    // Loading side
    logic [LEN_W-1:0]   cur_slen_reg;
    logic [LEN_W-1:0]   cur_olen_reg;
    logic [PT_W-1:0]    pair_total_reg;
    logic [BASE_W-1:0]  load_base_reg;
    logic               accept;
    logic               room;
    logic               src_we;
    logic               obs_we;
    logic               close;
    logic [LEN_W-1:0]   olen_next;
    logic [BASE_W-1:0]  src_wsum;
    logic [BASE_W-1:0]  obs_wsum;

    // Training side
    logic [TAB_AW-1:0]  idx_reg;
    logic [ITER_W-1:0]  iter_reg;
    logic [PT_W-1:0]    p_reg;
    logic [BASE_W-1:0]  pbase_reg;
    logic [LEN_W-1:0]   j_reg;
    logic [LEN_W-1:0]   i_reg;
    logic [LEN_W-1:0]   slen_reg;
    logic [LEN_W-1:0]   olen_reg;
    logic [VOC_W-1:0]   o_reg;
    logic [VOC_W-1:0]   s_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [DEN_W-1:0]   total_reg;
    logic [BASE_W-1:0]  src_rsum;
    logic [BASE_W-1:0]  obs_rsum;

    // Memories
    logic [WORD_W-1:0]  src_rdata;
    logic [WORD_W-1:0]  obs_rdata;
    logic [2*LEN_W-1:0] plen_rdata;
    logic               prob_we;
    logic [TAB_AW-1:0]  prob_waddr;
    logic [PROB_W-1:0]  prob_wdata;
    logic [TAB_AW-1:0]  prob_raddr;
    logic [PROB_W-1:0]  prob_rdata;
    logic               cnt_we;
    logic [TAB_AW-1:0]  cnt_waddr;
    logic [CNT_W-1:0]   cnt_wdata;
    logic [CNT_W-1:0]   cnt_rdata;
    logic [TAB_AW-1:0]  os_addr;

    // Divider
    logic               div_start;
    logic [NUM_W-1:0]   div_num;
    logic [DEN_W-1:0]   div_den;
    logic               div_done;
    logic [QUO_W-1:0]   div_quo;
    logic [CNT_W:0]     cnt_sum;
    logic [PROB_W-1:0]  norm_val;

    // Output register
    logic               out_valid_reg;
    logic [WORD_W-1:0]  out_obs_reg;
    logic [WORD_W-1:0]  out_src_reg;
    logic [PROB_W-1:0]  out_prob_reg;
    logic               out_last_reg;

    assign ns = (cfg_src_vocab > SRC_LIM) ? SRC_LIM : cfg_src_vocab;
    assign no = (cfg_obs_vocab > OBS_LIM) ? OBS_LIM : cfg_obs_vocab;

    assign accept    = s_valid && cmd.in_ready;
    assign room      = (pair_total_reg < PT_W'(MAX_PAIRS));
    assign src_we    = accept && room && (s_operation == OP_SRC)
                       && (cur_slen_reg < LEN_W'(MAX_LEN));
    assign obs_we    = accept && room && (s_operation == OP_OBS)
                       && (cur_olen_reg < LEN_W'(MAX_LEN));
    assign close     = accept && room && (s_operation == OP_OBS) && s_end_of_pair;
    assign olen_next = obs_we ? cur_olen_reg + 1'b1 : cur_olen_reg;
    assign src_wsum  = load_base_reg + BASE_W'(cur_slen_reg);
    assign obs_wsum  = load_base_reg + BASE_W'(cur_olen_reg);
    assign src_rsum  = pbase_reg + BASE_W'(i_reg);
    assign obs_rsum  = pbase_reg + BASE_W'(j_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_slen_reg   <= '0;
            cur_olen_reg   <= '0;
            pair_total_reg <= '0;
            load_base_reg  <= '0;
        end else begin
            if (close) begin
                cur_slen_reg   <= '0;
                cur_olen_reg   <= '0;
                pair_total_reg <= pair_total_reg + 1'b1;
                load_base_reg  <= load_base_reg + BASE_W'(MAX_LEN);
            end else begin
                if (src_we) begin
                    cur_slen_reg <= cur_slen_reg + 1'b1;
                end
                if (obs_we) begin
                    cur_olen_reg <= cur_olen_reg + 1'b1;
                end
            end
        end
    end

    ibm1em_ram #(.WIDTH(WORD_W), .DEPTH(WDEPTH)) u_src_words (
        .aclk  (aclk),
        .we    (src_we),
        .waddr (WA_W'(src_wsum)),
        .wdata (s_word),
        .raddr (WA_W'(src_rsum)),
        .rdata (src_rdata)
    );

    ibm1em_ram #(.WIDTH(WORD_W), .DEPTH(WDEPTH)) u_obs_words (
        .aclk  (aclk),
        .we    (obs_we),
        .waddr (WA_W'(obs_wsum)),
        .wdata (s_word),
        .raddr (WA_W'(obs_rsum)),
        .rdata (obs_rdata)
    );

    ibm1em_ram #(.WIDTH(2 * LEN_W), .DEPTH(MAX_PAIRS)) u_pair_lengths (
        .aclk  (aclk),
        .we    (close),
        .waddr (PA_W'(pair_total_reg)),
        .wdata ({cur_slen_reg, olen_next}),
        .raddr (PA_W'(p_reg)),
        .rdata (plen_rdata)
    );

    assign os_addr    = {o_reg[WORD_W-1:0], s_reg[WORD_W-1:0]};
    assign prob_raddr = cmd.prob_addr_word ? {o_reg[WORD_W-1:0], src_rdata} : os_addr;

    assign cnt_sum   = {1'b0, cnt_rdata} + (CNT_W + 1)'(div_quo);
    assign norm_val  = (stat.total_zero) ? '0 :
                       (div_quo > QUO_W'(PROB_ONE)) ? PROB_ONE : div_quo[PROB_W-1:0];

    assign prob_we    = cmd.prob_wr_uni || cmd.prob_wr_norm;
    assign prob_waddr = cmd.prob_wr_uni ? idx_reg : os_addr;
    assign prob_wdata = cmd.prob_wr_uni ? uni_prob(no) : norm_val;

    assign cnt_we    = cmd.cnt_wr_zero || cmd.cnt_wr_acc;
    assign cnt_waddr = cmd.cnt_wr_zero ? idx_reg : os_addr;
    assign cnt_wdata = cmd.cnt_wr_zero ? '0 :
                       cnt_sum[CNT_W] ? CNT_MAX : cnt_sum[CNT_W-1:0];

    ibm1em_ram #(.WIDTH(PROB_W), .DEPTH(TAB_DEPTH)) u_prob_table (
        .aclk  (aclk),
        .we    (prob_we),
        .waddr (prob_waddr),
        .wdata (prob_wdata),
        .raddr (prob_raddr),
        .rdata (prob_rdata)
    );

    ibm1em_ram #(.WIDTH(CNT_W), .DEPTH(TAB_DEPTH)) u_count_table (
        .aclk  (aclk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (os_addr),
        .rdata (cnt_rdata)
    );

    // Share: round(t * 2^16 / sum). New probability: round(count * 2^15 / total).
    assign div_start = cmd.div_start_share || cmd.div_start_norm;
    assign div_num   = cmd.div_start_share
                       ? (NUM_W'(prob_rdata) << SHARE_SHIFT) + NUM_W'(sum_reg >> 1)
                       : (NUM_W'(cnt_rdata) << NORM_SHIFT) + NUM_W'(total_reg >> 1);
    assign div_den   = cmd.div_start_share ? DEN_W'(sum_reg) : total_reg;

    ibm1em_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg  <= '0;
            iter_reg <= '0;
        end else begin
            if (cmd.idx_clr) begin
                idx_reg <= '0;
            end else if (cmd.idx_inc) begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.iter_clr) begin
                iter_reg <= '0;
            end else if (cmd.iter_inc) begin
                iter_reg <= iter_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.pair_clr) begin
            p_reg     <= '0;
            pbase_reg <= '0;
        end else if (cmd.pair_next) begin
            p_reg     <= p_reg + 1'b1;
            pbase_reg <= pbase_reg + BASE_W'(MAX_LEN);
        end
        if (cmd.plen_latch) begin
            {slen_reg, olen_reg} <= plen_rdata;
        end
        if (cmd.j_clr) begin
            j_reg <= '0;
        end else if (cmd.j_inc) begin
            j_reg <= j_reg + 1'b1;
        end
        if (cmd.i_clr) begin
            i_reg <= '0;
        end else if (cmd.i_inc) begin
            i_reg <= i_reg + 1'b1;
        end
        if (cmd.o_latch) begin
            o_reg <= {1'b0, obs_rdata};
        end else if (cmd.o_clr) begin
            o_reg <= '0;
        end else if (cmd.o_inc) begin
            o_reg <= o_reg + 1'b1;
        end
        if (cmd.s_latch) begin
            s_reg <= {1'b0, src_rdata};
        end else if (cmd.s_clr) begin
            s_reg <= '0;
        end else if (cmd.s_inc) begin
            s_reg <= s_reg + 1'b1;
        end
        if (cmd.sum_clr) begin
            sum_reg <= '0;
        end else if (cmd.sum_acc && (s_reg < ns)) begin
            sum_reg <= sum_reg + SUM_W'(prob_rdata);
        end
        if (cmd.total_clr) begin
            total_reg <= '0;
        end else if (cmd.total_acc) begin
            total_reg <= total_reg + DEN_W'(cnt_rdata);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_obs_reg  <= o_reg[WORD_W-1:0];
            out_src_reg  <= s_reg[WORD_W-1:0];
            out_prob_reg <= prob_rdata;
            out_last_reg <= stat.o_last && (s_reg == ns - 1'b1);
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_observed_index = out_obs_reg;
    assign m_source_index   = out_src_reg;
    assign m_probability    = out_prob_reg;
    assign m_last           = out_last_reg;

    always_comb begin
        stat.train_req  = accept && (s_operation == OP_TRAIN);
        stat.idx_last   = (idx_reg == TAB_AW'(TAB_DEPTH - 1));
        stat.iter_hit   = (iter_reg == cfg_iterations);
        stat.p_end      = (p_reg == pair_total_reg);
        stat.j_end      = (j_reg == olen_reg);
        stat.obs_ok     = ({1'b0, obs_rdata} < no);
        stat.i_end      = (i_reg == slen_reg);
        stat.sum_zero   = (sum_reg == '0);
        stat.src_ok     = ({1'b0, src_rdata} < ns);
        stat.s_end      = (s_reg == ns);
        stat.o_end      = (o_reg == no);
        stat.o_last     = (o_reg == no - 1'b1);
        stat.total_zero = (total_reg == '0);
        stat.div_done   = div_done;
        stat.out_accept = out_valid_reg && m_ready;
        stat.out_last   = out_last_reg;
        stat.emit_empty = (ns == '0) || (no == '0);
    end

endmodule

// ===== rtl/core/ibm1em_ctrl.sv =====
module ibm1em_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  ibm1em_pkg::stat_t  stat,
    output ibm1em_pkg::cmd_t   cmd
);
    import ibm1em_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (stat.train_req) state_next = ST_INIT;
            ST_INIT:     if (stat.idx_last) state_next = ST_ITER_END;
            ST_ITER_END: state_next = stat.iter_hit ? ST_EM_START : ST_CLEAR;
            ST_CLEAR:    if (stat.idx_last) state_next = ST_PAIR_CHK;
            ST_PAIR_CHK: state_next = stat.p_end ? ST_NS_CHK : ST_PAIR_LD;
            ST_PAIR_LD:  state_next = ST_OBS_CHK;
            ST_OBS_CHK:  state_next = stat.j_end ? ST_PAIR_CHK : ST_OBS_LD;
            ST_OBS_LD:   state_next = stat.obs_ok ? ST_SUM_CHK : ST_OBS_CHK;
            ST_SUM_CHK: begin
                if (!stat.i_end) begin
                    state_next = ST_SUM_SRC;
                end else if (stat.sum_zero) begin
                    state_next = ST_OBS_CHK;
                end else begin
                    state_next = ST_SH_CHK;
                end
            end
            ST_SUM_SRC:  state_next = ST_SUM_ADD;
            ST_SUM_ADD:  state_next = ST_SUM_CHK;
            ST_SH_CHK:   state_next = stat.i_end ? ST_OBS_CHK : ST_SH_SRC;
            ST_SH_SRC:   state_next = stat.src_ok ? ST_SH_PROB : ST_SH_CHK;
            ST_SH_PROB:  state_next = ST_SH_DIV;
            ST_SH_DIV:   if (stat.div_done) state_next = ST_SH_CHK;
            ST_NS_CHK:   state_next = stat.s_end ? ST_ITER_END : ST_NT_CHK;
            ST_NT_CHK:   state_next = stat.o_end ? ST_NQ_CHK : ST_NT_ACC;
            ST_NT_ACC:   state_next = ST_NT_CHK;
            ST_NQ_CHK:   state_next = stat.o_end ? ST_NS_CHK : ST_NQ_RD;
            ST_NQ_RD:    state_next = stat.total_zero ? ST_NQ_CHK : ST_NQ_DIV;
            ST_NQ_DIV:   if (stat.div_done) state_next = ST_NQ_CHK;
            ST_EM_START: state_next = stat.emit_empty ? ST_IDLE : ST_EM_RD;
            ST_EM_RD:    state_next = ST_EM_LD;
            ST_EM_LD:    state_next = ST_EM_WAIT;
            ST_EM_WAIT: begin
                if (stat.out_accept) begin
                    state_next = stat.out_last ? ST_IDLE : ST_EM_RD;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        case (state_reg)
            ST_IDLE: begin
                cmd.in_ready = 1'b1;
                cmd.idx_clr  = 1'b1;
            end
            ST_INIT: begin
                cmd.prob_wr_uni = 1'b1;
                cmd.idx_inc     = 1'b1;
                cmd.iter_clr    = stat.idx_last;
            end
            ST_CLEAR: begin
                cmd.cnt_wr_zero = 1'b1;
                cmd.idx_inc     = 1'b1;
                cmd.pair_clr    = stat.idx_last;
            end
            ST_PAIR_CHK: cmd.s_clr = stat.p_end;
            ST_PAIR_LD: begin
                cmd.plen_latch = 1'b1;
                cmd.j_clr      = 1'b1;
            end
            ST_OBS_CHK: cmd.pair_next = stat.j_end;
            ST_OBS_LD: begin
                cmd.o_latch = 1'b1;
                cmd.i_clr   = stat.obs_ok;
                cmd.sum_clr = stat.obs_ok;
                cmd.j_inc   = !stat.obs_ok;
            end
            ST_SUM_CHK: begin
                cmd.j_inc = stat.i_end && stat.sum_zero;
                cmd.i_clr = stat.i_end && !stat.sum_zero;
            end
            ST_SUM_SRC: begin
                cmd.s_latch        = 1'b1;
                cmd.prob_addr_word = 1'b1;
            end
            ST_SUM_ADD: begin
                cmd.sum_acc = 1'b1;
                cmd.i_inc   = 1'b1;
            end
            ST_SH_CHK: cmd.j_inc = stat.i_end;
            ST_SH_SRC: begin
                cmd.s_latch        = 1'b1;
                cmd.prob_addr_word = 1'b1;
                cmd.i_inc          = !stat.src_ok;
            end
            ST_SH_PROB: cmd.div_start_share = 1'b1;
            ST_SH_DIV: begin
                cmd.cnt_wr_acc = stat.div_done;
                cmd.i_inc      = stat.div_done;
            end
            ST_NS_CHK: begin
                cmd.iter_inc  = stat.s_end;
                cmd.o_clr     = !stat.s_end;
                cmd.total_clr = !stat.s_end;
            end
            ST_NT_CHK: cmd.o_clr = stat.o_end;
            ST_NT_ACC: begin
                cmd.total_acc = 1'b1;
                cmd.o_inc     = 1'b1;
            end
            ST_NQ_CHK: cmd.s_inc = stat.o_end;
            ST_NQ_RD: begin
                cmd.prob_wr_norm   = stat.total_zero;
                cmd.o_inc          = stat.total_zero;
                cmd.div_start_norm = !stat.total_zero;
            end
            ST_NQ_DIV: begin
                cmd.prob_wr_norm = stat.div_done;
                cmd.o_inc        = stat.div_done;
            end
            ST_EM_START: begin
                cmd.s_clr = 1'b1;
                cmd.o_clr = 1'b1;
            end
            ST_EM_LD: cmd.out_load = 1'b1;
            ST_EM_WAIT: begin
                if (stat.out_accept && !stat.out_last) begin
                    cmd.o_clr = stat.o_last;
                    cmd.s_inc = stat.o_last;
                    cmd.o_inc = !stat.o_last;
                end
            end
            default: cmd = '0;
        endcase
    end

endmodule

// ===== rtl/core/ibm_model1_em_training.sv =====
// IBM Model 1 EM trainer. Sentence pairs are loaded one word per input
// transaction (operation 0 appends a source word, operation 1 an observed
// word, end_of_pair on an observed word closes the pair); loading takes one
// transaction per cycle. Operation 2 starts training: every probability is
// set to round(32768/observed_vocab_used), then iteration_count EM
// iterations run over the closed pairs, and the table is sent out as
// source_vocab_used * observed_vocab_used result transactions, source-major,
// with last on the final one. One shared divider, one quotient bit per cycle,
// sets the training time: an iteration clears the count table, then per
// closed pair reads each observed word (skipping one out of vocabulary),
// sums its in-vocabulary source probabilities and does one share division
// per in-vocabulary source word, then normalizes each source column, one
// division per entry of a nonzero column. Input is not taken while a train
// command is in progress; each result is loaded and held until m_ready.
// Probabilities are unsigned Q1.15, counts saturate at 24 bits (Q8.16), and
// a column whose count total is zero becomes all zero. Loaded pairs stay
// across train commands; a word beyond the length or pair limit is dropped.
module ibm_model1_em_training #(
    parameter int SRC_VOCAB = 8,
    parameter int OBS_VOCAB = 8,
    parameter int MAX_PAIRS = 16,
    parameter int MAX_LEN   = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ibm1em_pkg::CFG_AW-1:0]  paddr,
    input  logic [ibm1em_pkg::CFG_DW-1:0]  pwdata,
    output logic [ibm1em_pkg::CFG_DW-1:0]  prdata,
    output logic                           pready,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [ibm1em_pkg::OP_W-1:0]    s_operation,
    input  logic [ibm1em_pkg::WORD_W-1:0]  s_word,
    input  logic                           s_end_of_pair,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [ibm1em_pkg::WORD_W-1:0]  m_observed_index,
    output logic [ibm1em_pkg::WORD_W-1:0]  m_source_index,
    output logic [ibm1em_pkg::PROB_W-1:0]  m_probability,
    output logic                           m_last
);
    import ibm1em_pkg::*;

    logic [VOC_W-1:0]  src_vocab_reg;
    logic [VOC_W-1:0]  obs_vocab_reg;
    logic [ITER_W-1:0] iterations_reg;
    logic              cfg_wr;
    logic [1:0]        cfg_sel;
    cmd_t              cmd;
    stat_t             stat;

    // The register file is written on the access phase of an APB write.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_sel = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_vocab_reg  <= RST_SRC_VOCAB;
            obs_vocab_reg  <= RST_OBS_VOCAB;
            iterations_reg <= RST_ITERATIONS;
        end else if (cfg_wr) begin
            case (cfg_sel)
                REG_SRC_VOCAB:  src_vocab_reg  <= pwdata[VOC_W-1:0];
                REG_OBS_VOCAB:  obs_vocab_reg  <= pwdata[VOC_W-1:0];
                REG_ITERATIONS: iterations_reg <= pwdata[ITER_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_sel)
            REG_SRC_VOCAB:  prdata = CFG_DW'(src_vocab_reg);
            REG_OBS_VOCAB:  prdata = CFG_DW'(obs_vocab_reg);
            REG_ITERATIONS: prdata = CFG_DW'(iterations_reg);
            default:        prdata = '0;
        endcase
    end

    // The controller sequences the training loops; the datapath holds the
    // word stores, the two tables, the loop counters and the divider.
    ibm1em_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .cmd     (cmd)
    );

    ibm1em_dp #(
        .SRC_VOCAB (SRC_VOCAB),
        .OBS_VOCAB (OBS_VOCAB),
        .MAX_PAIRS (MAX_PAIRS),
        .MAX_LEN   (MAX_LEN)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .stat             (stat),
        .cfg_src_vocab    (src_vocab_reg),
        .cfg_obs_vocab    (obs_vocab_reg),
        .cfg_iterations   (iterations_reg),
        .s_valid          (s_valid),
        .s_operation      (s_operation),
        .s_word           (s_word),
        .s_end_of_pair    (s_end_of_pair),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_observed_index (m_observed_index),
        .m_source_index   (m_source_index),
        .m_probability    (m_probability),
        .m_last           (m_last)
    );

    assign s_ready = cmd.in_ready;

`ifndef SYNTHESIS
    // No input transaction is taken while a result is pending.
    a_no_load_while_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input accepted while a result is pending");

    // The final result returns the block to idle.
    a_last_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last) |=> s_ready)
        else $error("block not idle after final result");

    // The two table write sources never collide.
    a_prob_wr_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.prob_wr_uni && cmd.prob_wr_norm) && !(cmd.cnt_wr_zero && cmd.cnt_wr_acc))
        else $error("conflicting table writes");

    // A division just started cannot report done in the next cycle.
    a_div_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.div_start_share || cmd.div_start_norm) |=> !stat.div_done)
        else $error("divider done too early");
`endif

endmodule
